// File: design/rpp_pkg.sv
// ----------------------------------------------------------------------------
// rpp_pkg
// Shared types and constants for the RIPv2 packet parser: the byte and result
// transfer payloads, status codes and sizing constants.
// ----------------------------------------------------------------------------
package rpp_pkg;

	// Default limit on route entries in one packet.
	localparam int MAX_ENTRIES_DEF = 25;

	// Depth of the result queue in front of the output port.
	localparam int OQ_DEPTH = 4;

	// Reciprocal of five for a 14-bit dividend: (x * RECIP5) >> RECIP5_SHIFT.
	localparam logic [15:0] RECIP5 = 16'd52429;
	localparam int RECIP5_SHIFT = 18;

	// Result kinds.
	localparam logic KIND_ENTRY  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// Packet status codes.
	localparam logic [3:0] ST_OK     = 4'd0;
	localparam logic [3:0] ST_TRUNC  = 4'd1;
	localparam logic [3:0] ST_CMD    = 4'd2;
	localparam logic [3:0] ST_VER    = 4'd3;
	localparam logic [3:0] ST_ZERO   = 4'd4;
	localparam logic [3:0] ST_SIZE   = 4'd5;
	localparam logic [3:0] ST_FAMILY = 4'd6;
	localparam logic [3:0] ST_TAG    = 4'd7;
	localparam logic [3:0] ST_MASK   = 4'd8;
	localparam logic [3:0] ST_METRIC = 4'd9;

	// RIP command values.
	localparam logic [1:0] CMD_NONE     = 2'd0;
	localparam logic [1:0] CMD_REQUEST  = 2'd1;
	localparam logic [1:0] CMD_RESPONSE = 2'd2;

	// One packet byte.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
	} in_item_t;

	// One result: a route entry or the closing packet status.
	typedef struct packed {
		logic        kind;
		logic [1:0]  command;
		logic [31:0] route_addr;
		logic [31:0] route_mask;
		logic [31:0] next_hop;
		logic [31:0] route_metric;
		logic [4:0]  entry_index;
		logic [4:0]  entry_count;
		logic [3:0]  status;
		logic        packet_end;
	} out_item_t;

endpackage

// File: design/rpp_count.sv
// ----------------------------------------------------------------------------
// rpp_count
// Entry count implied by the IP total length and header length. Checks that
// the payload after the IP header is 12 bytes plus a whole number of 20-byte entries within
// the entry limit. Two steps: reciprocal multiply, then check.
// ----------------------------------------------------------------------------
module rpp_count #(
	parameter int MAX_ENTRIES = rpp_pkg::MAX_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        en,
	input  logic [15:0] tot,
	input  logic [5:0]  hl,
	output logic        ok,
	output logic [4:0]  count
);
	import rpp_pkg::*;

	logic [16:0] need;
	logic [16:0] rem;
	logic [13:0] x;
	logic [29:0] prod;

	logic [29:0] prod_q;
	logic [13:0] x_q;
	logic [1:0]  low_q;
	logic        neg_q;

	logic [11:0] quo;
	logic [13:0] quo5;

	// Remaining payload after the RIP header, in groups of four bytes.
	always_comb begin
		need = {11'd0, hl} + 17'd12;
		rem  = {1'b0, tot} - need;
		x    = rem[15:2];
		prod = 30'(x) * 30'(RECIP5);
	end

	// Product register.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= prod;
			x_q    <= x;
			low_q  <= rem[1:0];
			neg_q  <= rem[16];
		end
	end

	// Quotient by twenty, remainder check and limit check.
	always_comb begin
		quo   = prod_q[29:RECIP5_SHIFT];
		quo5  = {quo, 2'b00} + {2'b00, quo};
		ok    = !neg_q && (low_q == 2'b00) && (quo5 == x_q) &&
			(quo <= 12'(MAX_ENTRIES));
		count = ok ? quo[4:0] : 5'd0;
	end

endmodule

// File: design/rpp_out_queue.sv
// ----------------------------------------------------------------------------
// rpp_out_queue
// Small result queue in front of the output port. Takes up to two results in
// one cycle, in order, and hands out one result per transfer.
// ----------------------------------------------------------------------------
module rpp_out_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push0,
	input  rpp_pkg::out_item_t item0,
	input  logic               push1,
	input  rpp_pkg::out_item_t item1,
	output logic               room2,
	output logic               valid,
	input  logic               stall,
	output rpp_pkg::out_item_t data
);
	import rpp_pkg::*;

	localparam int AW = $clog2(OQ_DEPTH);
	localparam int CW = $clog2(OQ_DEPTH + 1);

	out_item_t         mem_q [OQ_DEPTH];
	logic [AW-1:0]     wr_q;
	logic [AW-1:0]     rd_q;
	logic [CW-1:0]     cnt_q;
	logic              pop;
	logic [AW-1:0]     wr_next;
	logic [CW-1:0]     n_push;

	always_comb begin
		pop     = (cnt_q != '0) && !stall;
		wr_next = wr_q + AW'(1);
		n_push  = CW'(push0) + CW'(push1);
		room2   = cnt_q <= CW'(OQ_DEPTH - 2);
		valid   = cnt_q != '0;
		data    = mem_q[rd_q];
	end

	// Storage: the second result goes behind the first.
	always_ff @(posedge clk) begin
		if (push0) begin
			mem_q[wr_q] <= item0;
		end
		if (push1) begin
			mem_q[wr_next] <= item1;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + AW'(n_push);
			cnt_q <= cnt_q + n_push - CW'(pop);
			if (pop) begin
				rd_q <= rd_q + AW'(1);
			end
		end
	end

endmodule

// File: design/rip_packet_parser.sv
// ----------------------------------------------------------------------------
// rip_packet_parser
// Parses an IPv4/UDP/RIPv2 packet one byte per transfer, checks the RIP
// header and each route entry, and reports valid entries and a closing status.
// ----------------------------------------------------------------------------
//
//  channel   | signals                                | moves
//  ----------+----------------------------------------+--------------------------
//  byte      | byte_valid, byte_stall, byte_data      | one packet byte + last
//  result    | result_valid, result_stall, result_data| route entry or status
//
// One byte is taken every cycle while byte_stall is low. A byte's results pass
// the input register, parse stage and entry count multiply registers and then
// wait in a four-deep queue. A byte that closes an entry and the packet gives
// two results. byte_stall rises only when the queue has fewer than two free
// slots. Reset clears the packet state, except the entry bytes, and empties the queue.
// ----------------------------------------------------------------------------
module rip_packet_parser #(
	parameter int MAX_ENTRIES = rpp_pkg::MAX_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  rpp_pkg::in_item_t  byte_data,
	output logic               result_valid,
	input  logic               result_stall,
	output rpp_pkg::out_item_t result_data
);
	import rpp_pkg::*;

	// Pipeline control.
	logic       en;
	logic       proc;

	// Input register.
	logic       valid_s1;
	in_item_t   data_s1;

	// Packet state.
	logic [15:0]           off_q;
	logic [5:0]            hlen_q;
	logic [15:0]           tlen_q;
	logic [1:0]            cmd_q;
	logic [3:0][3:0][7:0]  ent_q;
	logic [4:0]            done_q;
	logic [3:0]            err_q;
	logic [4:0]            pos_q;

	// Updated state before the end-of-packet clear.
	logic [15:0]           u_off;
	logic [5:0]            u_hlen;
	logic [15:0]           u_tlen;
	logic [1:0]            u_cmd;
	logic [3:0][3:0][7:0]  u_ent;
	logic [4:0]            u_done;
	logic [3:0]            u_err;
	logic [4:0]            u_pos;

	logic [7:0]  b;
	logic        in_range;
	logic [16:0] d;
	logic [15:0] dl;
	logic        past_hdr;
	logic [3:0]  idx;
	logic [31:0] inv;
	logic        ent_fire;
	logic [3:0]  st_code;
	logic        size_ok;

	// Parse stage results.
	logic        ent_v_s2;
	logic        sta_v_s2;
	logic [1:0]  cmd_s2;
	logic [3:0][31:0] words_s2;
	logic [4:0]  idx_s2;
	logic [3:0]  code_s2;
	logic [15:0] tot_s2;
	logic [5:0]  hl_s2;
	logic        ge4_s2;

	// Count stage results.
	logic        ent_v_s3;
	logic        sta_v_s3;
	logic [1:0]  cmd_s3;
	logic [3:0][31:0] words_s3;
	logic [4:0]  idx_s3;
	logic [3:0]  code_s3;
	logic        ge4_s3;

	logic        res_ok;
	logic [4:0]  res_count;
	logic [4:0]  cnt_out;
	out_item_t   ent_item;
	out_item_t   sta_item;
	logic        room2;

	// The whole pipeline moves when the queue can take two results.
	always_comb begin
		en         = room2;
		proc       = valid_s1 && en;
		byte_stall = valid_s1 && !en;
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || en) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!valid_s1 || en) begin
			data_s1 <= byte_data;
		end
	end

	// Size check on the stored lengths, ready well before the RIP header ends.
	rpp_count #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_size_chk (
		.clk  (clk),
		.en   (1'b1),
		.tot  (tlen_q),
		.hl   (hlen_q),
		.ok   (size_ok),
		.count()
	);

	// Byte parse: field decode, checks and entry capture.
	always_comb begin
		b        = data_s1.data_byte;
		in_range = (off_q < 16'd4) || (off_q < tlen_q);
		d        = {1'b0, off_q} - {11'd0, hlen_q};
		dl       = d[15:0];
		past_hdr = !d[16] && (dl >= 16'd8);
		idx      = 4'(pos_q - 5'd4);
		inv      = '0;
		ent_fire = 1'b0;

		u_hlen = hlen_q;
		u_tlen = tlen_q;
		u_cmd  = cmd_q;
		u_ent  = ent_q;
		u_done = done_q;
		u_err  = err_q;

		if (in_range) begin
			if (off_q == 16'd0) begin
				u_hlen = {b[3:0], 2'b00};
			end else if (off_q == 16'd2) begin
				u_tlen = {b, 8'h00};
			end else if (off_q == 16'd3) begin
				u_tlen = {tlen_q[15:8], b};
			end else if (err_q == ST_OK && past_hdr) begin
				if (dl == 16'd8) begin
					if (b == 8'(CMD_REQUEST) || b == 8'(CMD_RESPONSE)) begin
						u_cmd = b[1:0];
					end else begin
						u_err = ST_CMD;
					end
				end else if (dl == 16'd9) begin
					if (b != 8'd2) begin
						u_err = ST_VER;
					end
				end else if (dl == 16'd10 || dl == 16'd11) begin
					if (b != 8'd0) begin
						u_err = ST_ZERO;
					end else if (dl == 16'd11 && !size_ok) begin
						u_err = ST_SIZE;
					end
				end else begin
					case (pos_q)
						5'd0: begin
							if (b != 8'd0) begin
								u_err = ST_FAMILY;
							end
						end
						5'd1: begin
							if (b != ((cmd_q == CMD_RESPONSE) ? 8'd2 : 8'd0)) begin
								u_err = ST_FAMILY;
							end
						end
						5'd2, 5'd3: begin
							if (b != 8'd0) begin
								u_err = ST_TAG;
							end
						end
						default: begin
							u_ent[idx[3:2]][~idx[1:0]] = b;
							if (pos_q == 5'd11) begin
								// Mask must be ones followed by zeros.
								inv = ~u_ent[1];
								if ((inv & (inv + 32'd1)) != 32'd0) begin
									u_err = ST_MASK;
								end
							end else if (pos_q == 5'd19) begin
								if (b < 8'd1 || b > 8'd16) begin
									u_err = ST_METRIC;
								end else begin
									ent_fire = 1'b1;
									u_done   = done_q + 5'd1;
								end
							end
						end
					endcase
				end
			end
		end

		// Offset saturates; entry position locks to the start of the entries.
		u_off = (off_q == 16'hffff) ? off_q : off_q + 16'd1;
		if (!d[16] && dl == 16'd11) begin
			u_pos = 5'd0;
		end else if (pos_q == 5'd19) begin
			u_pos = 5'd0;
		end else begin
			u_pos = pos_q + 5'd1;
		end

		// Closing status, truncation first.
		if (u_off < 16'd4 || u_off < u_tlen) begin
			st_code = ST_TRUNC;
		end else if (u_err != ST_OK) begin
			st_code = u_err;
		end else if ({1'b0, u_tlen} < {11'd0, u_hlen} + 17'd12) begin
			st_code = ST_SIZE;
		end else begin
			st_code = ST_OK;
		end
	end

	// Packet state; the last byte returns everything to its reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q  <= '0;
			hlen_q <= '0;
			tlen_q <= '0;
			cmd_q  <= CMD_NONE;
			done_q <= '0;
			err_q  <= ST_OK;
			pos_q  <= '0;
		end else if (proc) begin
			if (data_s1.last) begin
				off_q  <= '0;
				hlen_q <= '0;
				tlen_q <= '0;
				cmd_q  <= CMD_NONE;
				done_q <= '0;
				err_q  <= ST_OK;
				pos_q  <= '0;
			end else begin
				off_q  <= u_off;
				hlen_q <= u_hlen;
				tlen_q <= u_tlen;
				cmd_q  <= u_cmd;
				done_q <= u_done;
				err_q  <= u_err;
				pos_q  <= u_pos;
			end
		end
	end

	// Entry bytes are all rewritten before an entry is reported.
	always_ff @(posedge clk) begin
		if (proc) begin
			ent_q <= u_ent;
		end
	end

	// Parse stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_v_s2 <= 1'b0;
			sta_v_s2 <= 1'b0;
		end else if (en) begin
			ent_v_s2 <= proc && ent_fire;
			sta_v_s2 <= proc && data_s1.last;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s2   <= u_cmd;
			words_s2 <= u_ent;
			idx_s2   <= done_q;
			code_s2  <= st_code;
			tot_s2   <= u_tlen;
			hl_s2    <= u_hlen;
			ge4_s2   <= u_off >= 16'd4;
		end
	end

	// Entry count for the reported results.
	rpp_count #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_res_count (
		.clk  (clk),
		.en   (en),
		.tot  (tot_s2),
		.hl   (hl_s2),
		.ok   (res_ok),
		.count(res_count)
	);

	// Count stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_v_s3 <= 1'b0;
			sta_v_s3 <= 1'b0;
		end else if (en) begin
			ent_v_s3 <= ent_v_s2;
			sta_v_s3 <= sta_v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s3   <= cmd_s2;
			words_s3 <= words_s2;
			idx_s3   <= idx_s2;
			code_s3  <= code_s2;
			ge4_s3   <= ge4_s2;
		end
	end

	// Result assembly.
	always_comb begin
		cnt_out = (res_ok && ge4_s3) ? res_count : 5'd0;

		ent_item              = '0;
		ent_item.kind         = KIND_ENTRY;
		ent_item.command      = cmd_s3;
		ent_item.route_addr   = words_s3[0];
		ent_item.route_mask   = words_s3[1];
		ent_item.next_hop     = words_s3[2];
		ent_item.route_metric = words_s3[3];
		ent_item.entry_index  = idx_s3;
		ent_item.entry_count  = cnt_out;

		sta_item             = '0;
		sta_item.kind        = KIND_STATUS;
		sta_item.command     = cmd_s3;
		sta_item.entry_count = cnt_out;
		sta_item.status      = code_s3;
		sta_item.packet_end  = 1'b1;
	end

	// Result queue; an entry goes ahead of the status from the same byte.
	rpp_out_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push0 (en && (ent_v_s3 || sta_v_s3)),
		.item0 (ent_v_s3 ? ent_item : sta_item),
		.push1 (en && ent_v_s3 && sta_v_s3),
		.item1 (sta_item),
		.room2 (room2),
		.valid (result_valid),
		.stall (result_stall),
		.data  (result_data)
	);

endmodule

// File: verif/rip_packet_parser_checker.sv
// ----------------------------------------------------------------------------
// rip_packet_parser_checker
// Watches both channels of the RIPv2 packet parser. Every accepted byte runs
// through a local parser that tracks the packet state and works out the
// route entries and closing status the block must produce. Every accepted
// result is compared field by field with the oldest outstanding one.
// ----------------------------------------------------------------------------
module rip_packet_parser_checker #(
	parameter int         MAX_ENTRIES = rpp_pkg::MAX_ENTRIES_DEF,
	parameter logic [7:0] RIP_VERSION = 8'd2,
	parameter logic [7:0] AF_INET     = 8'd2,
	parameter logic [7:0] METRIC_MAX  = 8'd16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	input  logic               byte_stall,
	input  rpp_pkg::in_item_t  byte_data,
	input  logic               result_valid,
	input  logic               result_stall,
	input  rpp_pkg::out_item_t result_data,
	output int                 fail_count,
	output int                 pending,
	output int                 predicted,
	output int                 compared
);
	timeunit 1ns;
	timeprecision 1ps;
	import rpp_pkg::*;

	localparam int FIXED_HDR   = 4;
	localparam int UDP_LEN     = 8;
	localparam int RIP_HDR_LEN = 4;
	localparam int ENTRY_LEN   = 20;
	localparam int OFFSET_MAX  = 65535;

	// Packet state of the local parser.
	int         offset;
	int         hdr_len;
	int         ip_total_len;
	int         routes_done;
	logic [1:0] rip_cmd;
	logic [3:0] first_err;
	logic [7:0] entry_buf [16];

	// Results still owed by the block, oldest first.
	out_item_t  parse_results [$];
	int         mismatches;
	int         n_predicted;
	int         n_compared;

	function automatic void clear_packet();
		offset = 0;
		hdr_len = 0;
		ip_total_len = 0;
		routes_done = 0;
		rip_cmd = CMD_NONE;
		first_err = ST_OK;
		foreach (entry_buf[i])
			entry_buf[i] = 8'h00;
	endfunction

	function automatic logic [31:0] entry_word(input int base);
		return {entry_buf[base], entry_buf[base + 1], entry_buf[base + 2], entry_buf[base + 3]};
	endfunction

	// Number of entries the total length calls for, or zero if it is not a legal size.
	function automatic int entries_implied();
		int need;
		int rem;
		need = hdr_len + UDP_LEN + RIP_HDR_LEN;
		if (offset < FIXED_HDR || ip_total_len < need)
			return 0;
		rem = ip_total_len - need;
		if (rem % ENTRY_LEN != 0 || rem / ENTRY_LEN > MAX_ENTRIES)
			return 0;
		return rem / ENTRY_LEN;
	endfunction

	// Advance the parse by one byte and queue whatever results it produces.
	function automatic void parse_byte(input in_item_t it);
		int         o;
		int         rip_at;
		int         slot;
		logic [7:0] b;
		logic [31:0] inv;
		logic [3:0] st;
		out_item_t  r;
		b = it.data_byte;
		o = offset;
		rip_at = hdr_len + UDP_LEN;
		if (o < FIXED_HDR || o < ip_total_len) begin
			if (o == 0) begin
				hdr_len = int'(b[3:0]) * 4;
			end else if (o == 2) begin
				ip_total_len = int'(b) << 8;
			end else if (o == 3) begin
				ip_total_len = (ip_total_len & 'hff00) | int'(b);
			end else if (first_err == ST_OK && o >= rip_at) begin
				if (o == rip_at) begin
					if (b == 8'(CMD_REQUEST) || b == 8'(CMD_RESPONSE))
						rip_cmd = b[1:0];
					else
						first_err = ST_CMD;
				end else if (o == rip_at + 1) begin
					if (b != RIP_VERSION)
						first_err = ST_VER;
				end else if (o == rip_at + 2 || o == rip_at + 3) begin
					// The last zero byte also settles whether the length is legal.
					if (b != 8'h00)
						first_err = ST_ZERO;
					else if (o == rip_at + 3 && entries_implied() == 0 &&
						ip_total_len != rip_at + RIP_HDR_LEN)
						first_err = ST_SIZE;
				end else begin
					slot = (o - rip_at - RIP_HDR_LEN) % ENTRY_LEN;
					if (slot == 0) begin
						if (b != 8'h00)
							first_err = ST_FAMILY;
					end else if (slot == 1) begin
						if (b != ((rip_cmd == CMD_RESPONSE) ? AF_INET : 8'h00))
							first_err = ST_FAMILY;
					end else if (slot < 4) begin
						if (b != 8'h00)
							first_err = ST_TAG;
					end else begin
						entry_buf[(slot - 4) & 15] = b;
						if (slot == 11) begin
							// A legal mask inverted is a run of low ones.
							inv = ~entry_word(4);
							if ((inv & (inv + 32'd1)) != 32'd0)
								first_err = ST_MASK;
						end else if (slot == ENTRY_LEN - 1) begin
							if (b == 8'h00 || b > METRIC_MAX) begin
								first_err = ST_METRIC;
							end else begin
								r = '0;
								r.kind = KIND_ENTRY;
								r.command = rip_cmd;
								r.route_addr = entry_word(0);
								r.route_mask = entry_word(4);
								r.next_hop = entry_word(8);
								r.route_metric = entry_word(12);
								r.entry_index = 5'(routes_done);
								r.entry_count = 5'(entries_implied());
								parse_results.push_back(r);
								n_predicted++;
								routes_done = (routes_done + 1) & 31;
							end
						end
					end
				end
			end
		end
		if (offset < OFFSET_MAX)
			offset++;

		// The last byte closes the packet with a status; truncation outranks all else.
		if (it.last) begin
			if (offset < FIXED_HDR || offset < ip_total_len)
				st = ST_TRUNC;
			else if (first_err != ST_OK)
				st = first_err;
			else if (ip_total_len < hdr_len + UDP_LEN + RIP_HDR_LEN)
				st = ST_SIZE;
			else
				st = ST_OK;
			r = '0;
			r.kind = KIND_STATUS;
			r.command = rip_cmd;
			r.entry_count = 5'(entries_implied());
			r.status = st;
			r.packet_end = 1'b1;
			parse_results.push_back(r);
			n_predicted++;
			clear_packet();
		end
	endfunction

	function automatic void compare_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	function automatic void check_result(input out_item_t want, input out_item_t got);
		compare_field("kind", want.kind, got.kind);
		compare_field("command", want.command, got.command);
		compare_field("route_addr", want.route_addr, got.route_addr);
		compare_field("route_mask", want.route_mask, got.route_mask);
		compare_field("next_hop", want.next_hop, got.next_hop);
		compare_field("route_metric", want.route_metric, got.route_metric);
		compare_field("entry_index", want.entry_index, got.entry_index);
		compare_field("entry_count", want.entry_count, got.entry_count);
		compare_field("status", want.status, got.status);
		compare_field("packet_end", want.packet_end, got.packet_end);
		n_compared++;
	endfunction

	// Sample both channels at each edge; counters go out registered.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_packet();
			parse_results.delete();
			mismatches = 0;
			n_predicted = 0;
			n_compared = 0;
			fail_count <= 0;
			pending <= 0;
			predicted <= 0;
			compared <= 0;
		end else begin
			if (byte_valid && !byte_stall)
				parse_byte(byte_data);
			if (result_valid && !result_stall) begin
				if (parse_results.size() == 0) begin
					$error("result transfer with nothing outstanding: kind %0d, status %0d",
						result_data.kind, result_data.status);
					mismatches++;
				end else begin
					check_result(parse_results.pop_front(), result_data);
				end
			end
			fail_count <= mismatches;
			pending <= parse_results.size();
			predicted <= n_predicted;
			compared <= n_compared;
		end
	end

endmodule

// File: verif/rip_packet_parser_tb.sv
// ----------------------------------------------------------------------------
// rip_packet_parser_tb
// Feeds the RIPv2 packet parser with directed packets (header and entry
// errors, size errors, truncation, trailing bytes, both header-length extremes)
// and then with random packets, mostly well formed with random content and
// partly damaged or pure noise. Both channels idle in random bursts; the
// checker beside the block reports any mismatch.
// ----------------------------------------------------------------------------
module rip_packet_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rpp_pkg::*;

	localparam int         HALF_PERIOD  = 6;
	localparam int         UDP_LEN      = 8;
	localparam int         RIP_HDR_LEN  = 4;
	localparam int         ENTRY_LEN    = 20;
	localparam int         RANDOM_BYTES = 250;
	localparam int         QUIET_TAIL   = 100;
	localparam int         DRAIN_CYCLES = 20;
	localparam logic [7:0] RIP_VERSION  = 8'd2;
	localparam logic [7:0] AF_INET      = 8'd2;
	localparam logic [7:0] METRIC_MAX   = 8'd16;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       byte_valid = 1'b0;
	logic       byte_stall;
	in_item_t   byte_data = '0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	out_item_t  result_data;

	int         fail_count;
	int         pending;
	int         predicted;
	int         compared;

	logic [7:0] pkt [$];
	int         pkt_hdr;
	bit         gaps_on = 1'b1;
	int         stall_left = 0;
	int         n_packets = 0;
	int         n_bytes = 0;
	int         rand_bytes = 0;

	rip_packet_parser u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_data    (byte_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

	rip_packet_parser_checker #(
		.MAX_ENTRIES (MAX_ENTRIES_DEF),
		.RIP_VERSION (RIP_VERSION),
		.AF_INET     (AF_INET),
		.METRIC_MAX  (METRIC_MAX)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_data    (byte_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data),
		.fail_count   (fail_count),
		.pending      (pending),
		.predicted    (predicted),
		.compared     (compared)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// Hard stop in case the block hangs.
	initial begin
		#10_000_000;
		$display("rip_packet_parser_tb failed");
		$finish;
	end

	// The result side stalls in random bursts while gaps are enabled.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else if (gaps_on && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(1, 15) - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	function automatic int entry_base(input int k);
		return pkt_hdr + UDP_LEN + RIP_HDR_LEN + ENTRY_LEN * k;
	endfunction

	function automatic void set_total(input int t);
		pkt[2] = 8'(t >> 8);
		pkt[3] = 8'(t);
	endfunction

	function automatic void trim_to(input int len);
		while (pkt.size() > len)
			void'(pkt.pop_back());
	endfunction

	// Set address, mask, next hop and upper metric bytes of an entry to one value.
	function automatic void fill_entry(input int at, input logic [7:0] value,
		input logic [7:0] metric);
		for (int i = 4; i < ENTRY_LEN - 1; i++)
			pkt[at + i] = value;
		pkt[at + ENTRY_LEN - 1] = metric;
	endfunction

	// Build a well-formed packet with random content and a matching total length.
	function automatic void make_packet(input int ihl, input logic [1:0] cmd, input int n_routes);
		int          total;
		int          at;
		int          plen;
		logic [31:0] mask;
		pkt_hdr = ihl * 4;
		total = entry_base(n_routes);
		pkt.delete();
		repeat (total)
			pkt.push_back(8'($urandom));
		pkt[0] = {4'd4, 4'(ihl)};
		set_total(total);
		pkt[pkt_hdr + UDP_LEN] = 8'(cmd);
		pkt[pkt_hdr + UDP_LEN + 1] = RIP_VERSION;
		pkt[pkt_hdr + UDP_LEN + 2] = 8'h00;
		pkt[pkt_hdr + UDP_LEN + 3] = 8'h00;
		for (int k = 0; k < n_routes; k++) begin
			at = entry_base(k);
			pkt[at] = 8'h00;
			pkt[at + 1] = (cmd == CMD_RESPONSE) ? AF_INET : 8'h00;
			pkt[at + 2] = 8'h00;
			pkt[at + 3] = 8'h00;
			plen = $urandom_range(0, 32);
			mask = (plen == 0) ? 32'd0 : (32'hffff_ffff << (32 - plen));
			for (int i = 0; i < 4; i++)
				pkt[at + 8 + i] = mask[31 - 8 * i -: 8];
			pkt[at + ENTRY_LEN - 1] = 8'($urandom_range(1, METRIC_MAX));
		end
	endfunction

	// One byte transfer, optionally preceded by an idle burst.
	task automatic send_byte(input in_item_t it);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 15))
				@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_data <= it;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
	endtask

	task automatic send_packet();
		for (int i = 0; i < pkt.size(); i++)
			send_byte(in_item_t'{data_byte: pkt[i], last: (i == pkt.size() - 1)});
		n_packets++;
		n_bytes += pkt.size();
	endtask

	// Mostly well-formed packets; the rest carry one kind of damage or are noise.
	task automatic random_packet();
		int         ihl;
		int         n;
		int         k;
		int         at;
		logic [1:0] cmd;
		ihl = ($urandom_range(0, 9) < 7) ? 5 : $urandom_range(0, 15);
		k = $urandom_range(0, 19);
		n = (k < 17) ? $urandom_range(0, 3) : (k < 19) ? $urandom_range(4, 8) : MAX_ENTRIES_DEF;
		cmd = $urandom_range(0, 1) ? CMD_RESPONSE : CMD_REQUEST;
		make_packet(ihl, cmd, n);
		k = $urandom_range(0, 99);
		if (k < 50) begin
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 6))
					pkt.push_back(8'($urandom));
		end else if (k < 55) begin
			pkt[pkt_hdr + UDP_LEN] = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(3, 255));
		end else if (k < 60) begin
			pkt[pkt_hdr + UDP_LEN + 1] ^= 8'($urandom_range(1, 255));
		end else if (k < 64) begin
			pkt[pkt_hdr + UDP_LEN + 2 + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
		end else if (k < 84 && n > 0) begin
			at = entry_base($urandom_range(0, n - 1));
			case ($urandom_range(0, 3))
				0: pkt[at + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
				1: pkt[at + 2 + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
				2: begin
					for (int i = 0; i < 4; i++)
						pkt[at + 8 + i] = 8'($urandom);
				end
				default: begin
					pkt[at + ENTRY_LEN - 1] = $urandom_range(0, 1) ? 8'h00 :
						8'($urandom_range(METRIC_MAX + 1, 255));
				end
			endcase
		end else if (k < 88) begin
			pkt[$urandom_range(0, pkt.size() - 1)] ^= 8'($urandom_range(1, 255));
		end else if (k < 92) begin
			set_total($urandom_range(0, pkt.size() + 30));
		end else if (k < 97) begin
			trim_to($urandom_range(1, pkt.size() - 1));
		end else begin
			pkt.delete();
			repeat ($urandom_range(1, 40))
				pkt.push_back(8'($urandom));
		end
	endtask

	initial begin
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Smallest legal packets and entries at the extremes of every field.
		make_packet(5, CMD_REQUEST, 0);
		send_packet();
		make_packet(5, CMD_RESPONSE, 1);
		fill_entry(entry_base(0), 8'hff, 8'd1);
		send_packet();
		make_packet(0, CMD_REQUEST, 2);
		fill_entry(entry_base(0), 8'h00, METRIC_MAX);
		send_packet();

		// Header errors: command, version and the two zero bytes.
		make_packet(0, CMD_REQUEST, 0);
		pkt[pkt_hdr + UDP_LEN] = 8'h00;
		send_packet();
		make_packet(0, CMD_RESPONSE, 0);
		pkt[pkt_hdr + UDP_LEN] = 8'hff;
		send_packet();
		make_packet(0, CMD_RESPONSE, 0);
		pkt[pkt_hdr + UDP_LEN + 1] = 8'd1;
		send_packet();
		make_packet(0, CMD_REQUEST, 0);
		pkt[pkt_hdr + UDP_LEN + 2] = 8'h80;
		send_packet();
		make_packet(0, CMD_RESPONSE, 0);
		pkt[pkt_hdr + UDP_LEN + 3] = 8'h01;
		send_packet();

		// Size errors: ragged length, length ending inside the RIP header,
		// length below the fixed header.
		make_packet(0, CMD_REQUEST, 0);
		repeat (7)
			pkt.push_back(8'($urandom));
		set_total(pkt.size());
		send_packet();
		make_packet(0, CMD_REQUEST, 0);
		set_total(pkt_hdr + UDP_LEN + 2);
		send_packet();
		make_packet(0, CMD_RESPONSE, 0);
		set_total(3);
		send_packet();

		// Entry errors: both family bytes, tag, mask and metric on either side.
		make_packet(0, CMD_RESPONSE, 1);
		pkt[entry_base(0)] = 8'd1;
		send_packet();
		make_packet(0, CMD_REQUEST, 1);
		pkt[entry_base(0) + 1] = AF_INET;
		send_packet();
		make_packet(0, CMD_RESPONSE, 1);
		pkt[entry_base(0) + 3] = 8'h40;
		send_packet();
		make_packet(0, CMD_RESPONSE, 1);
		for (int i = 0; i < 4; i++)
			pkt[entry_base(0) + 8 + i] = (i % 2 == 0) ? 8'hff : 8'h00;
		send_packet();
		make_packet(0, CMD_REQUEST, 1);
		pkt[entry_base(0) + ENTRY_LEN - 1] = 8'h00;
		send_packet();
		make_packet(0, CMD_RESPONSE, 1);
		pkt[entry_base(0) + ENTRY_LEN - 1] = METRIC_MAX + 8'd1;
		send_packet();

		// A good entry followed by a bad one: the first still comes out.
		make_packet(0, CMD_RESPONSE, 2);
		pkt[entry_base(1) + ENTRY_LEN - 1] = 8'h00;
		send_packet();

		// Truncation: inside the length field, on the first byte, and after an error.
		make_packet(5, CMD_REQUEST, 0);
		trim_to(3);
		send_packet();
		make_packet(5, CMD_RESPONSE, 0);
		trim_to(1);
		send_packet();
		make_packet(0, CMD_RESPONSE, 2);
		pkt[pkt_hdr + UDP_LEN] = 8'h07;
		trim_to(pkt.size() - 5);
		send_packet();

		// Bytes past the total length are ignored; the longest header length.
		make_packet(0, CMD_RESPONSE, 1);
		repeat (10)
			pkt.push_back(8'($urandom));
		send_packet();
		make_packet(15, CMD_REQUEST, 1);
		send_packet();

		// Random packets; the final stretch runs with no idling on either side.
		while (rand_bytes < RANDOM_BYTES) begin
			gaps_on = (rand_bytes < RANDOM_BYTES - QUIET_TAIL) && ($urandom_range(0, 4) != 0);
			random_packet();
			rand_bytes += pkt.size();
			send_packet();
		end
		gaps_on = 1'b0;
		byte_valid <= 1'b0;

		do
			@(posedge clk);
		while (pending != 0);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		$display("Sent %0d packets in %0d byte transfers; %0d results were compared.",
			n_packets, n_bytes, compared);
		if (fail_count == 0) begin
			$display("rip_packet_parser_tb passed");
		end else begin
			$display("rip_packet_parser_tb failed");
		end
		$finish;
	end

endmodule
